// ===== hw/rtl/rs_pkg.sv =====
// Shared constants and unit handshake types for the three-axis running statistics core.
// No dependencies.
package rs_pkg;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int SPREAD_BITS     = 64;
    localparam int FIELD_BITS      = 16;
    localparam int AXES            = 3;
    localparam int OUT_BITS        = 4 * AXES * FIELD_BITS;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
    } unit_sts_t;
endpackage

// ===== hw/rtl/three_axis_running_stats_core.sv =====
// Three-axis running statistics: min, max, truncated mean and Welford spread per axis.
// Depends on rs_pkg, rs_div, rs_sqrt, rs_mul.
//
// Input channel s_axis: tuser is the item kind (sample or report), tdata the x, y, z
// samples. The first sample after reset or a report is taken in the idle state. Every
// later sample runs the axes in turn through a serial divider and a serial multiplier.
// Samples past a saturated count are dropped. A report runs, per axis, a division of
// the spread by the count and a square root; a report with no samples skips both.
// The report result goes to the m_axis output register and all statistics clear.
// s_axis_tready is high only while no item is in progress. A stalled m_axis holds the
// result; the block keeps taking samples meanwhile, and a further report waits for
// the pending result to leave. Reset clears all statistics and drops any pending
// result.
module three_axis_running_stats_core #(
    parameter int SAMPLE_BITS = rs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rs_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // sample_x, sample_y, sample_z
    input  logic                        s_axis_tuser,  // kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rs_pkg::OUT_BITS-1:0] m_axis_tdata   // lowest_x/y/z, highest_x/y/z,
                                                       // mean_x/y/z, deviation_x/y/z
);
    import rs_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int DSW = $clog2(SPREAD_BITS + 1);
    localparam int RW  = SPREAD_BITS / 2;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_S_LAUNCH = 8'b0000_0010,
        ST_S_DIV    = 8'b0000_0100,
        ST_S_MUL    = 8'b0000_1000,
        ST_R_LAUNCH = 8'b0001_0000,
        ST_R_DIV    = 8'b0010_0000,
        ST_R_SQRT   = 8'b0100_0000,
        ST_R_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0]          count_reg, count_next;
    logic signed [SB-1:0]   min_reg [AXES], min_next [AXES];
    logic signed [SB-1:0]   max_reg [AXES], max_next [AXES];
    logic signed [SB-1:0]   mean_reg [AXES], mean_next [AXES];
    logic [SPREAD_BITS-1:0] spread_reg [AXES], spread_next [AXES];
    logic signed [SB-1:0]   smp_reg [AXES], smp_next [AXES];
    logic [FIELD_BITS-1:0]  dev_reg [AXES], dev_next [AXES];
    logic [1:0]             axis_reg, axis_next;
    logic [SB:0]            dmag_reg, dmag_next;
    logic                   dneg_reg, dneg_next;
    logic                   pneg_reg, pneg_next;
    logic [OUT_BITS-1:0]    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    unit_ctl_t div_ctl, sqrt_ctl, mul_ctl;
    unit_sts_t div_sts, sqrt_sts, mul_sts;
    logic [SPREAD_BITS-1:0] div_dividend, div_q;
    logic [DSW-1:0]         div_steps;
    logic [RW-1:0]          sqrt_root;
    logic [2*SB+1:0]        mul_p;
    logic [SB:0]            mul_a;

    logic                   s_fire;
    logic [SB-1:0]          in_smp [AXES];
    logic signed [SB:0]     d_cur;
    logic [SB:0]            quot;
    logic [SB:0]            qs;
    logic signed [SB-1:0]   nm;
    logic signed [SB:0]     a_cur;
    logic [SPREAD_BITS-1:0] term;
    logic                   count_full;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign count_full = (count_reg == {CB{1'b1}});
    assign in_smp[0]  = s_axis_tdata[SB-1:0];
    assign in_smp[1]  = s_axis_tdata[16+SB-1:16];
    assign in_smp[2]  = s_axis_tdata[32+SB-1:32];

    assign d_cur = {smp_reg[axis_reg][SB-1], smp_reg[axis_reg]}
                   - {mean_reg[axis_reg][SB-1], mean_reg[axis_reg]};
    assign quot  = div_q[SB:0];
    assign qs    = dneg_reg ? (~quot + 1'b1) : quot;
    assign nm    = mean_reg[axis_reg] + qs[SB-1:0];
    assign a_cur = {smp_reg[axis_reg][SB-1], smp_reg[axis_reg]} - {nm[SB-1], nm};
    assign mul_a = a_cur[SB] ? (~a_cur + 1'b1) : a_cur;
    assign term  = pneg_reg ? (~{{(SPREAD_BITS-2*SB-2){1'b0}}, mul_p} + 1'b1)
                            : {{(SPREAD_BITS-2*SB-2){1'b0}}, mul_p};

    assign div_dividend = (state_reg == ST_S_LAUNCH)
                          ? {dmag_next, {(SPREAD_BITS-SB-1){1'b0}}}
                          : spread_reg[axis_reg];
    assign div_steps    = (state_reg == ST_S_LAUNCH) ? DSW'(SB + 1) : DSW'(SPREAD_BITS);

    rs_div #(.DW(SPREAD_BITS), .VW(CB), .SW(DSW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .sts      (div_sts),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .steps    (div_steps),
        .quotient (div_q)
    );

    rs_sqrt #(.VW(SPREAD_BITS)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sqrt_ctl),
        .sts   (sqrt_sts),
        .value (div_q),
        .root  (sqrt_root)
    );

    rs_mul #(.W(SB + 1)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .sts     (mul_sts),
        .a       (mul_a),
        .b       (dmag_reg),
        .product (mul_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        mean_next      = mean_reg;
        spread_next    = spread_reg;
        smp_next       = smp_reg;
        dev_next       = dev_reg;
        axis_next      = axis_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        pneg_next      = pneg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_ctl.start  = 1'b0;
        sqrt_ctl.start = 1'b0;
        mul_ctl.start  = 1'b0;
        s_axis_tready  = (state_reg == ST_IDLE);

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == KIND_REPORT)
                    begin
                        axis_next  = '0;
                        state_next = (count_reg == '0) ? ST_R_FIN : ST_R_LAUNCH;
                    end
                    else if (!count_full)
                    begin
                        count_next = count_reg + 1'b1;
                        for (int i = 0; i < AXES; i++)
                        begin
                            smp_next[i] = in_smp[i];
                            if (count_reg == '0)
                            begin
                                min_next[i]  = in_smp[i];
                                max_next[i]  = in_smp[i];
                                mean_next[i] = in_smp[i];
                            end
                            else
                            begin
                                if ($signed(in_smp[i]) < min_reg[i])
                                begin
                                    min_next[i] = in_smp[i];
                                end
                                if ($signed(in_smp[i]) > max_reg[i])
                                begin
                                    max_next[i] = in_smp[i];
                                end
                            end
                        end
                        if (count_reg != '0)
                        begin
                            axis_next  = '0;
                            state_next = ST_S_LAUNCH;
                        end
                    end
                end
            end
            ST_S_LAUNCH:
            begin
                dneg_next     = d_cur[SB];
                dmag_next     = d_cur[SB] ? (~d_cur + 1'b1) : d_cur;
                div_ctl.start = 1'b1;
                state_next    = ST_S_DIV;
            end
            ST_S_DIV:
            begin
                if (div_sts.done)
                begin
                    mean_next[axis_reg] = nm;
                    pneg_next           = a_cur[SB] ^ dneg_reg;
                    mul_ctl.start       = 1'b1;
                    state_next          = ST_S_MUL;
                end
            end
            ST_S_MUL:
            begin
                if (mul_sts.done)
                begin
                    spread_next[axis_reg] = spread_reg[axis_reg] + term;
                    if (axis_reg == 2'(AXES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_S_LAUNCH;
                    end
                end
            end
            ST_R_LAUNCH:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                if (div_sts.done)
                begin
                    sqrt_ctl.start = 1'b1;
                    state_next     = ST_R_SQRT;
                end
            end
            ST_R_SQRT:
            begin
                if (sqrt_sts.done)
                begin
                    dev_next[axis_reg] = (sqrt_root[RW-1:FIELD_BITS] != '0)
                                         ? {FIELD_BITS{1'b1}} : sqrt_root[FIELD_BITS-1:0];
                    if (axis_reg == 2'(AXES - 1))
                    begin
                        state_next = ST_R_FIN;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_R_LAUNCH;
                    end
                end
            end
            ST_R_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        out_next[i*FIELD_BITS +: FIELD_BITS] =
                            FIELD_BITS'(signed'(min_reg[i]));
                        out_next[(AXES+i)*FIELD_BITS +: FIELD_BITS] =
                            FIELD_BITS'(signed'(max_reg[i]));
                        out_next[(2*AXES+i)*FIELD_BITS +: FIELD_BITS] =
                            FIELD_BITS'(signed'(mean_reg[i]));
                        out_next[(3*AXES+i)*FIELD_BITS +: FIELD_BITS] =
                            (count_reg == '0) ? '0 : dev_reg[i];
                        min_next[i]    = '0;
                        max_next[i]    = '0;
                        mean_next[i]   = '0;
                        spread_next[i] = '0;
                    end
                    count_next     = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                min_reg[i]    <= '0;
                max_reg[i]    <= '0;
                mean_reg[i]   <= '0;
                spread_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            mean_reg      <= mean_next;
            spread_reg    <= spread_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        dev_reg  <= dev_next;
        dmag_reg <= dmag_next;
        dneg_reg <= dneg_next;
        pneg_reg <= pneg_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_sat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser == KIND_SAMPLE && count_full) |=> $stable(count_reg))
        else $error("saturated count changed on a sample");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_R_FIN && (!out_valid_reg || m_axis_tready))
        |=> (count_reg == '0 && m_axis_tvalid))
        else $error("report did not clear statistics or present result");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({div_sts.done, sqrt_sts.done, mul_sts.done}))
        else $error("two serial units finished together");
`endif
endmodule

// ===== hw/rtl/rs_div.sv =====
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on rs_pkg.
module rs_div #(
    parameter int DW = 64,
    parameter int VW = 24,
    parameter int SW = $clog2(DW + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rs_pkg::unit_ctl_t  ctl,
    output rs_pkg::unit_sts_t  sts,
    input  logic [DW-1:0]      dividend,
    input  logic [VW-1:0]      divisor,
    input  logic [SW-1:0]      steps,
    output logic [DW-1:0]      quotient
);
    import rs_pkg::*;

    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] d_reg, d_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;

    assign shifted = {r_reg, q_reg[DW-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = steps;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = diff[VW-1:0];
                q_next = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[VW-1:0];
                q_next = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign sts.done = done_reg;
    assign quotient = q_reg;
endmodule

// ===== hw/rtl/rs_sqrt.sv =====
// Bit-pair serial floor square root, one root bit per cycle.
// Depends on rs_pkg.
module rs_sqrt #(
    parameter int VW = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rs_pkg::unit_ctl_t  ctl,
    output rs_pkg::unit_sts_t  sts,
    input  logic [VW-1:0]      value,
    output logic [VW/2-1:0]    root
);
    import rs_pkg::*;

    localparam int RW = VW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [VW-1:0] v_reg, v_next;
    logic [RW:0]   rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;

    assign rem_sh = {rem_reg, v_reg[VW-1:VW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            v_next    = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            v_next = {v_reg[VW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[RW:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[RW:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign sts.done = done_reg;
    assign root     = root_reg;
endmodule

// ===== hw/rtl/rs_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on rs_pkg.
module rs_mul #(
    parameter int W = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rs_pkg::unit_ctl_t  ctl,
    output rs_pkg::unit_sts_t  sts,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    output logic [2*W-1:0]     product
);
    import rs_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = {acc_reg[2*W-2:0], 1'b0}
                       + (b_reg[W-1] ? {{W{1'b0}}, a_reg} : '0);
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign sts.done = done_reg;
    assign product  = acc_reg;
endmodule
